[sv/bitmap_text_to_page_framebuffer_core_macros.svh]
// ----------------------------------------------------------------------------
// bitmap text renderer assertion macros
// shared concurrent assertion forms, clocked on clk and idle in reset
// ----------------------------------------------------------------------------
`ifndef BITMAP_TEXT_TO_PAGE_FRAMEBUFFER_CORE_MACROS_SVH
`define BITMAP_TEXT_TO_PAGE_FRAMEBUFFER_CORE_MACROS_SVH

// consequent must hold in the same cycle
`define BTPF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the next cycle
`define BTPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/btpf_pkg.sv]
// ----------------------------------------------------------------------------
// btpf_pkg
// commands, font table and glyph lookup for the bitmap text renderer
// ----------------------------------------------------------------------------
`default_nettype none

package btpf_pkg;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_CLEAR = 2'd0;
	localparam cmd_t CMD_TEXT  = 2'd1;
	localparam cmd_t CMD_READ  = 2'd2;

	localparam int unsigned GLYPH_COLS  = 5;
	localparam int unsigned GLYPH_ROWS  = 7;
	localparam int unsigned GLYPH_PITCH = 6;

	// five columns times two pages per glyph
	localparam logic [3:0] DRAW_STEPS = 4'd10;

	// wide enough for any store address at the largest panel
	localparam int unsigned FULL_AW = 14;

	localparam logic [5:0] SLOT_DIGIT0 = 6'd0;
	localparam logic [5:0] SLOT_CAP_A  = 6'd10;
	localparam logic [5:0] SLOT_DASH   = 6'd36;
	localparam logic [5:0] SLOT_DOT    = 6'd37;
	localparam logic [5:0] SLOT_COLON  = 6'd38;
	localparam logic [5:0] SLOT_BLANK  = 6'd39;

	typedef logic [GLYPH_ROWS-1:0] glyph_col_t;
	typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] glyph_t;

	function automatic logic [5:0] glyph_slot(input logic [7:0] code);
		logic [5:0] slot;
		slot = SLOT_BLANK;
		if (code >= 8'd48 && code <= 8'd57) begin
			slot = SLOT_DIGIT0 + 6'(code - 8'd48);
		end else if (code >= 8'd65 && code <= 8'd90) begin
			slot = SLOT_CAP_A + 6'(code - 8'd65);
		end else if (code == 8'd45) begin
			slot = SLOT_DASH;
		end else if (code == 8'd46) begin
			slot = SLOT_DOT;
		end else if (code == 8'd58) begin
			slot = SLOT_COLON;
		end
		return slot;
	endfunction

	function automatic glyph_col_t font_col(input logic [5:0] slot, input logic [2:0] col);
		glyph_t g;
		case (slot)
			6'd0: begin g = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E}; end
			6'd1: begin g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00}; end
			6'd2: begin g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46}; end
			6'd3: begin g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31}; end
			6'd4: begin g = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10}; end
			6'd5: begin g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39}; end
			6'd6: begin g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30}; end
			6'd7: begin g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03}; end
			6'd8: begin g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36}; end
			6'd9: begin g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E}; end
			6'd10: begin g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}; end
			6'd11: begin g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36}; end
			6'd12: begin g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}; end
			6'd13: begin g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C}; end
			6'd14: begin g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}; end
			6'd15: begin g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01}; end
			6'd16: begin g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A}; end
			6'd17: begin g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F}; end
			6'd18: begin g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}; end
			6'd19: begin g = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01}; end
			6'd20: begin g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}; end
			6'd21: begin g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40}; end
			6'd22: begin g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F}; end
			6'd23: begin g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F}; end
			6'd24: begin g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}; end
			6'd25: begin g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06}; end
			6'd26: begin g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E}; end
			6'd27: begin g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46}; end
			6'd28: begin g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31}; end
			6'd29: begin g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01}; end
			6'd30: begin g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}; end
			6'd31: begin g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F}; end
			6'd32: begin g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F}; end
			6'd33: begin g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63}; end
			6'd34: begin g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07}; end
			6'd35: begin g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43}; end
			6'd36: begin g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08}; end
			6'd37: begin g = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00}; end
			6'd38: begin g = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00}; end
			default: begin g = '0; end
		endcase
		return (col < 3'(GLYPH_COLS)) ? g[col] : '0;
	endfunction

endpackage

`default_nettype wire

[sv/btpf_store.sv]
// ----------------------------------------------------------------------------
// btpf_store
// frame store: one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module btpf_store #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[sv/bitmap_text_to_page_framebuffer_core.sv]
// ----------------------------------------------------------------------------
// bitmap_text_to_page_framebuffer_core
// 5x7 text renderer into a page-organised monochrome frame store
// ----------------------------------------------------------------------------
// Takes one item at a time; in_stall is high from acceptance until the item's
// work is done. After reset, and for every clear item, the store is swept to
// zero one byte a cycle over PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) bytes (1024
// at the default size), during which no item is taken. A text character runs
// through the accepting step, ten read-modify-write slots (five glyph columns
// over two pages) through the single store write port, and one drain step; a
// character that does not fit wholly before the right edge is not drawn. A
// read waits in the read state for the output register to be free.
`default_nettype none
`include "bitmap_text_to_page_framebuffer_core_macros.svh"

module bitmap_text_to_page_framebuffer_core #(
	parameter int unsigned PANEL_WIDTH  = 128,
	parameter int unsigned PANEL_HEIGHT = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] command,
	input  wire logic       start_text,
	input  wire logic [7:0] x_pos,
	input  wire logic [7:0] y_pos,
	input  wire logic [7:0] char_code,
	input  wire logic [9:0] byte_index,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [7:0] read_data
);

	localparam int unsigned PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
	localparam int unsigned STORE_DEPTH = PANEL_WIDTH * PAGE_COUNT;
	localparam int unsigned AW          = $clog2(STORE_DEPTH);
	localparam int unsigned FAW         = btpf_pkg::FULL_AW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_DRAW  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [3:0]    step_q;
	logic [7:0]    cursor_q;
	logic [7:0]    row_q;
	logic [5:0]    slot_q;
	logic          hit_q;
	logic          out_valid_q;
	logic [7:0]    read_data_q;

	logic          en_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    mask_s1;
	logic [7:0]    data_s1;

	logic          in_accept;
	logic          out_free;
	logic [7:0]    cur_new;
	logic [7:0]    row_new;
	logic          fits;
	logic [FAW-1:0] idx_ext;
	logic          idx_hit;

	// shared shift and merge unit for one glyph byte
	logic [2:0]    col_off;
	logic          part;
	logic [6:0]    glyph;
	logic [15:0]   sh_data;
	logic [15:0]   sh_mask;
	logic [4:0]    page;
	logic          page_ok;
	logic [7:0]    hmask;
	logic [7:0]    bmask;
	logic [7:0]    bdata;
	logic [7:0]    col;
	logic [FAW-1:0] addr_full;
	logic          draw_en;

	logic          st_wr_en;
	logic [AW-1:0] st_wr_addr;
	logic [7:0]    st_wr_data;
	logic          st_rd_en;
	logic [AW-1:0] st_rd_addr;
	logic [7:0]    st_rd_data;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	assign cur_new = start_text ? x_pos : cursor_q;
	assign row_new = start_text ? y_pos : row_q;
	assign fits    = (9'(cur_new) + 9'(btpf_pkg::GLYPH_COLS)) <= 9'(PANEL_WIDTH);
	assign idx_ext = FAW'(byte_index);
	assign idx_hit = idx_ext < FAW'(STORE_DEPTH);

	always_comb begin
		col_off = step_q[3:1];
		part    = step_q[0];
		glyph   = btpf_pkg::font_col(slot_q, col_off);
		sh_data = 16'(glyph) << row_q[2:0];
		sh_mask = 16'(7'h7F) << row_q[2:0];
		// the second page wraps with the row
		page    = part ? (row_q[7:3] + 5'd1) : row_q[7:3];
		page_ok = 6'(page) < 6'(PAGE_COUNT);
		for (int b = 0; b < 8; b++) begin
			hmask[b] = {1'b0, page, 3'(b)} < 9'(PANEL_HEIGHT);
		end
		bdata     = part ? sh_data[15:8] : sh_data[7:0];
		bmask     = (part ? sh_mask[15:8] : sh_mask[7:0]) & hmask;
		col       = cursor_q + 8'(col_off);
		addr_full = FAW'(page) * FAW'(PANEL_WIDTH) + FAW'(col);
		draw_en   = (state_q == ST_DRAW) && (step_q != btpf_pkg::DRAW_STEPS)
			&& page_ok && (bmask != 8'd0);
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			st_wr_en   = 1'b1;
			st_wr_addr = clr_q;
			st_wr_data = 8'd0;
		end else begin
			st_wr_en   = en_s1;
			st_wr_addr = addr_s1;
			st_wr_data = (st_rd_data & ~mask_s1) | (data_s1 & mask_s1);
		end
		if (state_q == ST_DRAW) begin
			st_rd_en   = draw_en;
			st_rd_addr = addr_full[AW-1:0];
		end else begin
			st_rd_en   = in_accept && (command == btpf_pkg::CMD_READ) && idx_hit;
			st_rd_addr = idx_ext[AW-1:0];
		end
	end

	btpf_store #(
		.DEPTH(STORE_DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (st_wr_en),
		.wr_addr(st_wr_addr),
		.wr_data(st_wr_data),
		.rd_en  (st_rd_en),
		.rd_addr(st_rd_addr),
		.rd_data(st_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			cursor_q    <= '0;
			row_q       <= '0;
			en_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			en_s1 <= draw_en;
			if (state_q == ST_READ && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (command)
							btpf_pkg::CMD_CLEAR: begin
								state_q <= ST_CLEAR;
								clr_q   <= '0;
							end
							btpf_pkg::CMD_TEXT: begin
								cursor_q <= cur_new;
								row_q    <= row_new;
								if (fits) begin
									state_q <= ST_DRAW;
									step_q  <= '0;
								end
							end
							btpf_pkg::CMD_READ: begin
								state_q <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRAW: begin
					if (step_q == btpf_pkg::DRAW_STEPS) begin
						state_q  <= ST_IDLE;
						cursor_q <= cursor_q + 8'(btpf_pkg::GLYPH_PITCH);
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_full[AW-1:0];
		mask_s1 <= bmask;
		data_s1 <= bdata;
		if (in_accept && command == btpf_pkg::CMD_TEXT) begin
			slot_q <= btpf_pkg::glyph_slot(char_code);
		end
		if (in_accept && command == btpf_pkg::CMD_READ) begin
			hit_q <= idx_hit;
		end
		if (state_q == ST_READ && out_free) begin
			read_data_q <= hit_q ? st_rd_data : 8'd0;
		end
	end

	`BTPF_ASSERT_NOW(a_wr_in_range, st_wr_en, 32'(st_wr_addr) < 32'(STORE_DEPTH), "store write beyond depth")
	`BTPF_ASSERT_NOW(a_merge_after_draw, en_s1, $past(state_q) == ST_DRAW, "merge write outside a draw")
	`BTPF_ASSERT_NOW(a_step_bound, state_q == ST_DRAW, step_q <= btpf_pkg::DRAW_STEPS, "draw step overrun")
	`BTPF_ASSERT_NEXT(a_cursor_adv, state_q == ST_DRAW && step_q == btpf_pkg::DRAW_STEPS, cursor_q == $past(cursor_q) + 8'(btpf_pkg::GLYPH_PITCH), "cursor did not advance")

endmodule

`default_nettype wire
